>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define SHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sha_ms assertion failed");

// Same-cycle implication.
`define SHA_ASSERT_IMP(lbl, ante, cons) \
  `SHA_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication.
`define SHA_ASSERT_NXT(lbl, ante, cons) \
  `SHA_ASSERT(lbl, (ante) |=> (cons))

`endif

>>> rtl/sha_ms_pkg.sv
`timescale 1ns / 1ps
package sha_ms_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned RoundW = 6;
  localparam int unsigned CountW = 4;
  localparam int unsigned WinD   = 16;

  localparam logic [CountW-1:0] LastMsgIdx  = 4'd15;
  localparam logic [RoundW-1:0] FirstExpand = 6'd16;
  localparam logic [RoundW-1:0] LastRound   = 6'd63;

  // one queued message word, tagged by the front end
  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [CountW-1:0] idx;
    logic              last;
  } item_t;

  typedef enum logic {
    ST_PASS,
    ST_EXPAND
  } back_state_e;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v,
                                            input int unsigned n);
    rotr = (v >> n) | (v << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] sig0(input logic [WordW-1:0] v);
    sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [WordW-1:0] sig1(input logic [WordW-1:0] v);
    sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

>>> rtl/sha_ms_front.sv
`timescale 1ns / 1ps
module sha_ms_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [sha_ms_pkg::WordW-1:0]    msg_word_i,
  output logic                            in_stall_o,
  input  logic                            full_i,
  output logic                            push_o,
  output sha_ms_pkg::item_t               push_item_o
);

  logic [sha_ms_pkg::CountW-1:0] word_count_q, word_count_d;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    push_item_o.word = msg_word_i;
    push_item_o.idx  = word_count_q;
    push_item_o.last = (word_count_q == sha_ms_pkg::LastMsgIdx);
  end

  // wraps 15 -> 0 on its own
  assign word_count_d = push_o ? word_count_q + 1'b1 : word_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= '0;
    end else begin
      word_count_q <= word_count_d;
    end
  end

endmodule

>>> rtl/sha_ms_queue.sv
`timescale 1ns / 1ps
module sha_ms_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sha_ms_pkg::item_t push_item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output sha_ms_pkg::item_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sha_ms_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/sha_ms_back.sv
`timescale 1ns / 1ps
module sha_ms_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  sha_ms_pkg::item_t               q_item_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sha_ms_pkg::WordW-1:0]    sched_word_o,
  output logic [sha_ms_pkg::RoundW-1:0]   round_index_o,
  output logic                            block_done_o
);

  sha_ms_pkg::back_state_e state_q, state_d;

  // win_q[15] is the newest word; win_q[k] holds W[t-16+k]
  logic [sha_ms_pkg::WordW-1:0]  win_q [sha_ms_pkg::WinD];
  logic [sha_ms_pkg::RoundW-1:0] rnd_q, rnd_d;

  logic                          out_valid_q, out_valid_d;
  logic [sha_ms_pkg::WordW-1:0]  out_word_q;
  logic [sha_ms_pkg::RoundW-1:0] out_round_q;
  logic                          out_done_q;

  logic                          out_free;
  logic                          load;
  logic [sha_ms_pkg::WordW-1:0]  new_word;
  logic [sha_ms_pkg::RoundW-1:0] ld_round;
  logic                          ld_done;
  logic [sha_ms_pkg::WordW-1:0]  exp_word;

  assign out_free = !out_valid_q || !out_stall_i;
  assign exp_word = sha_ms_pkg::sig1(win_q[14]) + win_q[9]
                  + sha_ms_pkg::sig0(win_q[1]) + win_q[0];

  // datapath control
  always_comb begin
    pop_o    = 1'b0;
    load     = 1'b0;
    new_word = q_item_i.word;
    ld_round = sha_ms_pkg::RoundW'(q_item_i.idx);
    ld_done  = 1'b0;
    unique case (state_q)
      sha_ms_pkg::ST_PASS: begin
        if (q_valid_i && out_free) begin
          pop_o = 1'b1;
          load  = 1'b1;
        end
      end
      sha_ms_pkg::ST_EXPAND: begin
        new_word = exp_word;
        ld_round = rnd_q;
        ld_done  = (rnd_q == sha_ms_pkg::LastRound);
        load     = out_free;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    unique case (state_q)
      sha_ms_pkg::ST_PASS: begin
        if (pop_o && q_item_i.last) begin
          state_d = sha_ms_pkg::ST_EXPAND;
          rnd_d   = sha_ms_pkg::FirstExpand;
        end
      end
      sha_ms_pkg::ST_EXPAND: begin
        if (load) begin
          rnd_d = rnd_q + 1'b1;
          if (rnd_q == sha_ms_pkg::LastRound) begin
            state_d = sha_ms_pkg::ST_PASS;
          end
        end
      end
      default: begin
        state_d = sha_ms_pkg::ST_PASS;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha_ms_pkg::ST_PASS;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < sha_ms_pkg::WinD - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[sha_ms_pkg::WinD-1] <= new_word;
      out_word_q  <= new_word;
      out_round_q <= ld_round;
      out_done_q  <= ld_done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sched_word_o  = out_word_q;
  assign round_index_o = out_round_q;
  assign block_done_o  = out_done_q;

endmodule

>>> rtl/sha256_message_schedule.sv
`timescale 1ns / 1ps
// SHA-256 message schedule. Feed the 16 message words of a block in order, one
// transfer each; the block returns W[0..63] with their round index, block_done
// set on W[63]. Words 0..14 each give one result. Word 15 gives W[15] and then
// W[16..63], one per cycle while the output is not stalled, from the single
// expansion adder (sigma1 + W[t-7] + sigma0 + W[t-16] over a 16-word shift
// window); no queued word is taken while the expansion runs. A small queue
// (QueueDepth entries) between the input counter and the back end takes words
// while the expansion runs or the output is stalled, until the queue is full.
module sha256_message_schedule #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] msg_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sched_word_o,
  output logic [5:0]  round_index_o,
  output logic        block_done_o
);

  logic              push, full, q_valid, pop;
  sha_ms_pkg::item_t push_item, head;

  sha_ms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .msg_word_i  (msg_word_i),
    .in_stall_o  (in_stall_o),
    .full_i      (full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  sha_ms_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  sha_ms_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sched_word_o  (sched_word_o),
    .round_index_o (round_index_o),
    .block_done_o  (block_done_o)
  );

endmodule

>>> rtl/sha_ms_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha_ms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [31:0] sched_word_i,
  input logic [5:0]  round_index_i,
  input logic        block_done_i
);

  // round index expected on the next output transfer
  logic [5:0] exp_round_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_round_q <= '0;
    end else if (out_valid_i && !out_stall_i) begin
      exp_round_q <= exp_round_q + 1'b1;
    end
  end

  `SHA_ASSERT_NXT(a_out_hold, out_valid_i && out_stall_i,
                  out_valid_i && $stable(sched_word_i) && $stable(round_index_i))
  `SHA_ASSERT_IMP(a_round_order, out_valid_i, round_index_i == exp_round_q)
  `SHA_ASSERT_IMP(a_done_last, out_valid_i, block_done_i == (round_index_i == 6'd63))

endmodule

bind sha256_message_schedule sha_ms_checker u_sha_ms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .sched_word_i  (sched_word_o),
  .round_index_i (round_index_o),
  .block_done_i  (block_done_o)
);
